// File: rtl/core/kli_pkg.sv
// Package for the keyframe linear interpolator: widths, status codes and operations.
// No dependencies.
`default_nettype none
package kli_pkg;
    localparam int MaxFrames = 256;
    localparam int MaxCoords = 8;
    localparam int FrameAw = $clog2(MaxFrames);
    localparam int CoordAw = $clog2(MaxCoords);
    localparam int KeyAw = FrameAw + CoordAw;
    localparam int FcW = FrameAw + 1;
    localparam int PcW = CoordAw + 1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DOF   = 3'd1,
        ST_ORDER = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] time_value;
        logic [31:0] coordinate_in;
        logic        frame_end;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] coordinate_out;
        logic [2:0]  coordinate_index;
        logic        last_of_run;
        logic [31:0] latest_time;
    } rsp_t;

    // Control and handshake between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [31:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/kli_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on kli_pkg.
`default_nettype none
interface kli_req_if;
    logic           valid;
    logic           ready;
    kli_pkg::req_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface kli_rsp_if;
    logic           valid;
    logic           ready;
    kli_pkg::rsp_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/keyframe_linear_interpolator.sv
// Keyframe linear interpolator. Add request: the result is registered in S_ADD; a query on
// an empty table answers in the cycle after accept. Query: S_QLAST fetches the last key, a linear
// search of one key per cycle, the bit-serial divider when interpolating, then S_RDA,
// S_RDB, S_MUL, S_SUM and S_OUT per coordinate through the shared multiplier, S_OUT waiting
// while the last result is unread. One request at a time; ready drops while a request is
// in work. Reset (rst_n, async) clears counts and control; key memories undefined until written.
`default_nettype none
module keyframe_linear_interpolator (
    input wire logic clk,
    input wire logic rst_n,
    kli_req_if.sink  req,
    kli_rsp_if.source rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_QLAST, S_QFIRST, S_SCAN, S_SCAN2, S_DIV,
        S_RDA, S_RDB, S_MUL, S_SUM, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] times_mem [kli_pkg::MaxFrames];
    logic [31:0] coords_mem [kli_pkg::MaxFrames * kli_pkg::MaxCoords];

    logic [kli_pkg::FcW-1:0]  fc_reg;
    logic [kli_pkg::PcW-1:0]  cpf_reg, pc_reg;
    logic [31:0] pend_reg, latest_reg, t_reg, tread_reg, ts_reg;
    logic        ovf_reg, end_reg;
    logic [31:0] cin_reg;
    logic [kli_pkg::FrameAw-1:0] seg_reg, ridx_reg;
    logic [kli_pkg::CoordAw-1:0] ci_reg;
    logic        interp_reg;
    logic [15:0] frac_reg;
    logic [31:0] ca_reg, cread_reg;
    logic signed [32:0] dlt_reg;
    logic signed [49:0] prod_reg;
    kli_pkg::rsp_t out_reg;
    logic        ovalid_reg;
    kli_pkg::div_cmd_t dcmd;
    kli_pkg::div_rsp_t drsp;
    logic [kli_pkg::FrameAw-1:0] raddr;
    logic [kli_pkg::KeyAw-1:0]   caddr;
    logic [kli_pkg::PcW-1:0]     pos, ncnt;
    logic [kli_pkg::PcW-1:0]     cpf_eff;
    logic signed [49:0] pq;

    kli_div u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .rsp(drsp));

    assign req.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign rsp.valid = ovalid_reg;
    assign rsp.payload = out_reg;
    assign cpf_eff = cpf_reg;
    assign pos = pc_reg;
    assign ncnt = (pc_reg >= kli_pkg::PcW'(kli_pkg::MaxCoords)) ? pc_reg : pc_reg + 1'b1;
    // Truncating division of the product by 65536 (toward zero).
    assign pq = (prod_reg + (prod_reg[49] ? 50'sd65535 : 50'sd0)) >>> 16;

    // Registered reads of both memories.
    always_ff @(posedge clk)
    begin
        tread_reg <= times_mem[raddr];
        cread_reg <= coords_mem[caddr];
    end

    // While the search moves on, the next key is fetched so that tread matches ridx.
    // The start coordinate is read in S_RDA and the end coordinate in S_RDB.
    always_comb
    begin
        raddr = ridx_reg;
        if (state_reg == S_SCAN && t_reg >= tread_reg)
            raddr = ridx_reg + 1'b1;
        caddr = {seg_reg + 1'b1, ci_reg};
        if (state_reg == S_RDA)
            caddr = {seg_reg, ci_reg};
    end

    always_comb
    begin
        dcmd.start = 1'b0;
        dcmd.num = {t_reg - ts_reg, 16'd0};
        dcmd.den = tread_reg - ts_reg;
        if (state_reg == S_SCAN2 && interp_reg)
            dcmd.start = 1'b1;
    end

    function automatic logic out_ok_add();
        logic [kli_pkg::PcW-1:0] n;
        logic ov;
        logic [31:0] pt;
        n = ncnt;
        ov = (pc_reg == '0) ? 1'b0 : ovf_reg;
        ov = ov | (pc_reg >= kli_pkg::PcW'(kli_pkg::MaxCoords));
        pt = (pc_reg == '0) ? t_reg : pend_reg;
        return !ov && !(cpf_reg != '0 && cpf_reg != n)
            && !(fc_reg != '0 && pt < latest_reg)
            && (fc_reg < kli_pkg::FcW'(kli_pkg::MaxFrames));
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD && !ovf_reg && pc_reg < kli_pkg::PcW'(kli_pkg::MaxCoords)
            && fc_reg < kli_pkg::FcW'(kli_pkg::MaxFrames))
            coords_mem[{fc_reg[kli_pkg::FrameAw-1:0], pc_reg[kli_pkg::CoordAw-1:0]}] <= cin_reg;
        if (state_reg == S_ADD && end_reg && out_ok_add())
            times_mem[fc_reg[kli_pkg::FrameAw-1:0]] <= (pc_reg == '0) ? t_reg : pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fc_reg <= '0;
            cpf_reg <= '0;
            pc_reg <= '0;
            pend_reg <= '0;
            latest_reg <= '0;
            ovf_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        t_reg <= req.payload.time_value;
                        cin_reg <= req.payload.coordinate_in;
                        end_reg <= req.payload.frame_end;
                        if (req.payload.operation == kli_pkg::OP_ADD)
                            state_reg <= S_ADD;
                        else if (fc_reg == '0 || cpf_reg == '0)
                        begin
                            out_reg <= '{kli_pkg::ST_EMPTY, 32'd0, 3'd0, 1'b1, latest_reg};
                            ovalid_reg <= 1'b1;
                        end
                        else
                        begin
                            ridx_reg <= kli_pkg::FrameAw'(fc_reg - 1'b1);
                            state_reg <= S_QLAST;
                        end
                    end
                end
                S_ADD:
                begin
                    logic [2:0] st;
                    logic ov;
                    logic [31:0] pt;
                    ov = (pc_reg == '0) ? 1'b0 : ovf_reg;
                    pt = (pc_reg == '0) ? t_reg : pend_reg;
                    st = kli_pkg::ST_OK;
                    if (pc_reg >= kli_pkg::PcW'(kli_pkg::MaxCoords))
                    begin
                        ov = 1'b1;
                        st = kli_pkg::ST_DOF;
                    end
                    else if (fc_reg >= kli_pkg::FcW'(kli_pkg::MaxFrames))
                        st = kli_pkg::ST_FULL;
                    pend_reg <= pt;
                    ovf_reg <= ov;
                    pc_reg <= ncnt;
                    if (end_reg)
                    begin
                        if (ov || (cpf_reg != '0 && cpf_reg != ncnt))
                            st = kli_pkg::ST_DOF;
                        else if (fc_reg != '0 && pt < latest_reg)
                            st = kli_pkg::ST_ORDER;
                        else if (fc_reg >= kli_pkg::FcW'(kli_pkg::MaxFrames))
                            st = kli_pkg::ST_FULL;
                        else
                        begin
                            st = kli_pkg::ST_OK;
                            fc_reg <= fc_reg + 1'b1;
                            latest_reg <= pt;
                            if (cpf_reg == '0)
                                cpf_reg <= ncnt;
                        end
                        pc_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                    out_reg <= '{st, 32'd0, 3'(pos), 1'b1,
                        (end_reg && st == kli_pkg::ST_OK) ? pt : latest_reg};
                    ovalid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_QLAST:
                begin
                    ridx_reg <= '0;
                    state_reg <= S_QFIRST;
                end
                S_QFIRST:
                begin
                    // tread holds the last key time.
                    interp_reg <= 1'b0;
                    ci_reg <= '0;
                    if (t_reg >= tread_reg)
                    begin
                        seg_reg <= kli_pkg::FrameAw'(fc_reg - 1'b1);
                        state_reg <= S_RDA;
                    end
                    else
                    begin
                        seg_reg <= '0;
                        ridx_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // tread holds the time of key ridx.
                    if (ridx_reg == '0 && t_reg < tread_reg)
                        state_reg <= S_RDA;
                    else if (t_reg < tread_reg)
                    begin
                        // Found the first key above t: segment is the one before.
                        seg_reg <= ridx_reg - 1'b1;
                        interp_reg <= 1'b1;
                        state_reg <= S_SCAN2;
                    end
                    else
                    begin
                        ts_reg <= tread_reg;
                        ridx_reg <= ridx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN2:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        frac_reg <= drsp.quot;
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:
                    state_reg <= S_RDB;
                S_RDB:
                begin
                    ca_reg <= cread_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    dlt_reg <= interp_reg ? ($signed({cread_reg[31], cread_reg})
                        - $signed({ca_reg[31], ca_reg})) : 33'sd0;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    prod_reg <= dlt_reg * $signed({1'b0, frac_reg});
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        out_reg <= '{kli_pkg::ST_OK, ca_reg + pq[31:0], 3'(ci_reg),
                            (kli_pkg::PcW'(ci_reg) + 1'b1 == cpf_eff), latest_reg};
                        ovalid_reg <= 1'b1;
                        if (kli_pkg::PcW'(ci_reg) + 1'b1 == cpf_eff)
                            state_reg <= S_IDLE;
                        else
                        begin
                            ci_reg <= ci_reg + 1'b1;
                            state_reg <= S_RDA;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // A result is never overwritten before it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
        else $error("result lost");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE)
        else $error("ready while busy");
    a_cpf: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg != '0 |-> cpf_reg != '0)
        else $error("frames without dof");
endmodule
`default_nettype wire

// File: rtl/core/kli_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
// Depends on kli_pkg.
`default_nettype none
module kli_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kli_pkg::div_cmd_t cmd,
    output kli_pkg::div_rsp_t      rsp
);
    logic [47:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [16:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] diff;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[31:0], num_reg[47]};
        diff = {1'b0, trial} - {2'b00, den_reg};
        if (cmd.start)
        begin
            num_next = cmd.num;
            den_next = cmd.den;
            rem_next = '0;
            q_next = '0;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[46:0], 1'b0};
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                q_next = {q_reg[15:0], 1'b1} | {q_reg[16], 16'd0};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[15:0], 1'b0} | {q_reg[16], 16'd0};
            end
            // Sticky bit 16 records any quotient bit above the fraction.
            if (q_reg[15])
                q_next[16] = 1'b1;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg[16] ? 16'hFFFF : q_reg[15:0];
endmodule
`default_nettype wire

// File: tb/tb_kli_scoreboard.sv
// Scoreboard for the keyframe interpolator testbench: a pose-table predictor and result queue.
// Depends on kli_pkg.
`timescale 1ns / 100ps
`default_nettype none
class kli_pose_scoreboard;
    logic [31:0] frame_times [kli_pkg::MaxFrames];
    logic [31:0] frame_coords [kli_pkg::MaxFrames * kli_pkg::MaxCoords];
    int unsigned frames;
    int unsigned dof;
    int unsigned pending;
    logic [31:0] pending_t;
    logic [31:0] newest_t;
    bit overflow;
    kli_pkg::rsp_t expected_q[$];
    int errors;

    function new();
        frames = 0;
        dof = 0;
        pending = 0;
        pending_t = '0;
        newest_t = '0;
        overflow = 0;
        errors = 0;
    endfunction

    function void push(logic [2:0] st, logic [31:0] c, logic [2:0] idx, logic last);
        kli_pkg::rsp_t r;
        r.status = st;
        r.coordinate_out = c;
        r.coordinate_index = idx;
        r.last_of_run = last;
        r.latest_time = newest_t;
        expected_q = {expected_q, r};
    endfunction

    function void note_request(kli_pkg::req_t q);
        int unsigned pos;
        int unsigned seg;
        int unsigned n;
        logic [2:0] st;
        logic [15:0] frac;
        logic [47:0] num;
        logic [31:0] den;
        longint a;
        longint b;
        longint r;
        bit interp;
        if (q.operation == kli_pkg::OP_ADD)
        begin
            pos = pending;
            st = kli_pkg::ST_OK;
            if (pos == 0)
            begin
                pending_t = q.time_value;
                overflow = 0;
            end
            if (pos >= kli_pkg::MaxCoords)
            begin
                overflow = 1;
                st = kli_pkg::ST_DOF;
            end
            else
            begin
                if (frames < kli_pkg::MaxFrames)
                    frame_coords[frames * kli_pkg::MaxCoords + pos] = q.coordinate_in;
                else
                    st = kli_pkg::ST_FULL;
                pending = pos + 1;
            end
            if (q.frame_end)
            begin
                if (overflow || (dof != 0 && dof != pending))
                    st = kli_pkg::ST_DOF;
                else if (frames > 0 && pending_t < newest_t)
                    st = kli_pkg::ST_ORDER;
                else if (frames >= kli_pkg::MaxFrames)
                    st = kli_pkg::ST_FULL;
                else
                begin
                    st = kli_pkg::ST_OK;
                    frame_times[frames] = pending_t;
                    frames++;
                    newest_t = pending_t;
                    if (dof == 0)
                        dof = pending;
                end
                pending = 0;
                overflow = 0;
            end
            push(st, '0, pos[2:0], 1'b1);
        end
        else
        begin
            if (frames == 0 || dof == 0)
            begin
                push(kli_pkg::ST_EMPTY, '0, '0, 1'b1);
                return;
            end
            n = dof;
            interp = 0;
            frac = '0;
            seg = 0;
            if (q.time_value >= frame_times[frames - 1])
                seg = frames - 1;
            else if (q.time_value >= frame_times[0])
            begin
                for (int i = 0; i + 1 < frames; i++)
                    if (frame_times[i] <= q.time_value
                        && frame_times[i + 1] > q.time_value)
                    begin
                        seg = i;
                        break;
                    end
                num = {q.time_value - frame_times[seg], 16'h0};
                den = frame_times[seg + 1] - frame_times[seg];
                if (den != 0)
                begin
                    frac = (num / den > 48'hFFFF) ? 16'hFFFF : 16'(num / den);
                    interp = 1;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                a = longint'($signed(frame_coords[seg * kli_pkg::MaxCoords + i]));
                r = a;
                if (interp)
                begin
                    b = longint'($signed(frame_coords[(seg + 1) * kli_pkg::MaxCoords + i]));
                    r = a + ((b - a) * longint'(frac)) / 65536;
                end
                push(kli_pkg::ST_OK, r[31:0], i[2:0], (i + 1 == n));
            end
        end
    endfunction

    function void check_result(kli_pkg::rsp_t got);
        kli_pkg::rsp_t want;
        if (expected_q.size() == 0)
        begin
            report("unexpected result", got, got);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want)
            report("field mismatch", got, want);
    endfunction

    function void report(string what, kli_pkg::rsp_t got, kli_pkg::rsp_t want);
        errors++;
        $display({"ERROR %s: got st=%0d c=%h i=%0d l=%0d t=%h ",
                  "want st=%0d c=%h i=%0d l=%0d t=%h"},
                 what, got.status, got.coordinate_out, got.coordinate_index, got.last_of_run,
                 got.latest_time, want.status, want.coordinate_out, want.coordinate_index,
                 want.last_of_run, want.latest_time);
    endfunction
endclass
`default_nettype wire

// File: tb/tb_top.sv
// Top-level testbench for keyframe_linear_interpolator: drives add and query requests,
// predicts every result with the scoreboard class and checks it. Depends on kli_pkg, kli_if.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    logic clk;
    logic rst_n;
    kli_req_if req_ch ();
    kli_rsp_if rsp_ch ();

    keyframe_linear_interpolator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    kli_pose_scoreboard pose_sb;

    // Idle percentages for sender and receiver; changed between phases.
    int send_idle_pct;
    int recv_idle_pct;
    // When set, the receiver stalls once for hold_cycles before resuming.
    bit hold_request;
    int hold_cycles;
    // Receiver-side bookkeeping of the hold-off.
    int hold_left;
    bit hold_started;
    longint cycle_count;
    // Current time base for well-formed frame sequences.
    logic [31:0] seq_time;
    int unsigned frame_dof;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        pose_sb = new();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Cycle counter; the limit covers the slowest legal run many times over.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: random ready, with an optional long hold-off to fill the block up.
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left = 0;
        hold_started = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                pose_sb.check_result(rsp_ch.payload);
            if (hold_request && !hold_started)
            begin
                hold_started = 1;
                hold_left = hold_cycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send one request, idling at random first; returns once it is accepted.
    // Valid stays high on return so that a following request can go back to back.
    task automatic send_request(logic op, logic [31:0] t, logic [31:0] c, logic fe);
        kli_pkg::req_t q;
        q.operation = op;
        q.time_value = t;
        q.coordinate_in = c;
        q.frame_end = fe;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= q;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pose_sb.note_request(q);
    endtask

    // A full keyframe of frame_dof coordinates at time t.
    task automatic send_frame(logic [31:0] t);
        for (int i = 0; i < frame_dof; i++)
            send_request(kli_pkg::OP_ADD, t, $urandom(), i == frame_dof - 1);
    endtask

    // The sender goes quiet until every expected result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pose_sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly valid frames with increasing times and queries between keys, with noise.
    task automatic random_phase(int count);
        int kind;
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                seq_time = seq_time + $urandom_range(1, 5000);
                send_frame(seq_time);
                k += frame_dof - 1;
            end
            else if (kind < 80)
                send_request(kli_pkg::OP_QUERY, seq_time - $urandom_range(0, 20000),
                             $urandom(), 1'b0);
            else if (kind < 88)
                send_request(kli_pkg::OP_QUERY, $urandom(), $urandom(),
                             1'($urandom_range(1)));
            else if (kind < 94)
                send_request(kli_pkg::OP_ADD, $urandom(), $urandom(), 1'($urandom_range(1)));
            else
                send_request(kli_pkg::OP_ADD, seq_time - $urandom_range(1, 100), $urandom(),
                             1'b1);
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 0;
        hold_cycles = 0;
        @(posedge rst_n);
        @(posedge clk);
        // Directed part: empty table, an overlong frame, first frame fixing the pose size.
        send_request(kli_pkg::OP_QUERY, 32'h0, 32'h0, 1'b0);
        for (int i = 0; i < 9; i++)
            send_request(kli_pkg::OP_ADD, 32'd10, 32'h0, i == 8);
        frame_dof = 8;
        send_request(kli_pkg::OP_ADD, 32'd100, 32'h8000_0000, 1'b0);
        send_request(kli_pkg::OP_ADD, 32'd999, 32'h7FFF_FFFF, 1'b0);
        for (int i = 2; i < 8; i++)
            send_request(kli_pkg::OP_ADD, 32'd0, $urandom(), i == 7);
        // Wrong size, then a time before the latest key.
        send_request(kli_pkg::OP_ADD, 32'd200, 32'h1, 1'b1);
        send_frame(32'd50);
        send_request(kli_pkg::OP_ADD, 32'd100, 32'h7FFF_FFFF, 1'b0);
        send_request(kli_pkg::OP_ADD, 32'd100, 32'h8000_0000, 1'b0);
        for (int i = 2; i < 8; i++)
            send_request(kli_pkg::OP_ADD, 32'd100, $urandom(), i == 7);
        send_frame(32'hFFFF_0000);
        // Before first key, at a repeated key time, interior, at and after the last key.
        send_request(kli_pkg::OP_QUERY, 32'd5, 32'h0, 1'b0);
        send_request(kli_pkg::OP_QUERY, 32'd100, 32'h0, 1'b0);
        send_request(kli_pkg::OP_QUERY, 32'h7FFF_0000, 32'h0, 1'b0);
        send_request(kli_pkg::OP_QUERY, 32'hFFFF_0000, 32'h0, 1'b0);
        send_request(kli_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0, 1'b1);
        seq_time = 32'hFFFF_0000;
        wait_drained();
        send_idle_pct = 11;
        recv_idle_pct = 50;
        random_phase(30);
        // Long receiver hold-off while requests keep coming.
        hold_cycles = 2000;
        hold_request = 1;
        random_phase(15);
        // Sender pause until everything has come back.
        wait_drained();
        send_idle_pct = 50;
        recv_idle_pct = 11;
        random_phase(35);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(40);
        // A pending partial frame stays invisible to a query.
        send_request(kli_pkg::OP_ADD, seq_time, 32'h1234, 1'b0);
        send_request(kli_pkg::OP_QUERY, seq_time, 32'h0, 1'b0);
        wait_drained();
        repeat (400) @(posedge clk);
        if (pose_sb.errors == 0 && pose_sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
